// ----- hw/rtl/chdp_pkg.sv -----
package chdp_pkg;

    // Presence window length in seconds (range 2 to 4096).
    localparam int WINDOW_SECONDS = 300;

    localparam int SLOTW = (WINDOW_SECONDS > 1) ? $clog2(WINDOW_SECONDS) : 1;
    localparam int CNTW  = $clog2(WINDOW_SECONDS + 1);

    // Fold the 32-bit second into a short word that keeps its residue:
    // each byte is weighted by 256**i mod WINDOW_SECONDS.
    localparam int FOLD_C0 = 1;
    localparam int FOLD_C1 = 256 % WINDOW_SECONDS;
    localparam int FOLD_C2 = 65536 % WINDOW_SECONDS;
    localparam int FOLD_C3 = 16777216 % WINDOW_SECONDS;
    localparam int FOLD_MAX = 255 * (FOLD_C0 + FOLD_C1 + FOLD_C2 + FOLD_C3);
    localparam int XW = $clog2(FOLD_MAX + 1);

    // Reciprocal for an exact floor(x / WINDOW_SECONDS) over x < 2**XW.
    localparam int SHIFT_K = XW + SLOTW;
    localparam int MW = XW + 1;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT_K) + 64'(WINDOW_SECONDS) - 64'd1) / 64'(WINDOW_SECONDS);
    localparam logic [MW-1:0] RECIP_M = RECIP_FULL[MW-1:0];
    localparam int PW = XW + MW;
    localparam int QW = PW - SHIFT_K;

    // Run counters saturate at 65536.
    localparam int RUN_W = 17;
    localparam logic [RUN_W-1:0] RUN_MAX = 17'h10000;

    typedef enum logic [1:0] {
        CFG_ZEROS_TO_INACTIVE     = 2'd0,
        CFG_SECONDS_TO_ACTIVE     = 2'd1,
        CFG_ZEROS_TO_FORGET       = 2'd2,
        CFG_MIN_SECONDS_IN_WINDOW = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] rate_count;
        logic [31:0] gps_second;
    } t_in_beat;

    typedef struct packed {
        logic       data_present;
        logic       channel_active;
        logic       was_active;
        logic [8:0] seconds_in_window;
    } t_out_beat;

    typedef struct packed {
        logic             rd_en;
        logic [SLOTW-1:0] rd_addr;
        logic             wr_en;
        logic [SLOTW-1:0] wr_addr;
        logic             wr_data;
    } t_win_req;

    typedef struct packed {
        logic       channel_active;
        logic       was_active;
        logic [8:0] seconds_in_window;
    } t_status;

endpackage

// ----- hw/rtl/chdp_slot.sv -----
module chdp_slot (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  chdp_pkg::t_in_beat            i_data,
    input  logic                          i_take,
    output logic                          o_ready,
    output logic                          o_valid,
    output logic                          o_present,
    output logic [chdp_pkg::SLOTW-1:0]    o_slot
);
    import chdp_pkg::*;

    localparam logic [XW-1:0] K0 = XW'(FOLD_C0);
    localparam logic [XW-1:0] K1 = XW'(FOLD_C1);
    localparam logic [XW-1:0] K2 = XW'(FOLD_C2);
    localparam logic [XW-1:0] K3 = XW'(FOLD_C3);
    localparam logic [XW-1:0] W_X = XW'(WINDOW_SECONDS);

    logic          r_a_v, r_b_v, r_c_v;
    logic          r_a_present, r_b_present, r_c_present;
    logic [31:0]   r_a_sec;
    logic [XW-1:0] r_b_x, r_c_x;
    logic [QW-1:0] r_c_q;

    logic          ready_a, ready_b, ready_c;
    logic [XW-1:0] n_x;
    logic [PW-1:0] prod;
    logic [XW-1:0] rem_x;

    assign ready_c = !r_c_v || i_take;
    assign ready_b = !r_b_v || ready_c;
    assign ready_a = !r_a_v || ready_b;
    assign o_ready = ready_a;

    // Byte fold: keeps the residue modulo the window length.
    assign n_x = XW'(r_a_sec[7:0])   * K0 + XW'(r_a_sec[15:8])  * K1
               + XW'(r_a_sec[23:16]) * K2 + XW'(r_a_sec[31:24]) * K3;

    assign prod  = PW'(r_b_x) * PW'(RECIP_M);
    assign rem_x = r_c_x - XW'(XW'(r_c_q) * W_X);

    assign o_valid   = r_c_v;
    assign o_present = r_c_present;
    assign o_slot    = rem_x[SLOTW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (ready_a) r_a_v <= i_accept;
            if (ready_b) r_b_v <= r_a_v;
            if (ready_c) r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_accept) begin
            r_a_present <= (i_data.rate_count != 16'd0);
            r_a_sec     <= i_data.gps_second;
        end
        if (ready_b && r_a_v) begin
            r_b_present <= r_a_present;
            r_b_x       <= n_x;
        end
        if (ready_c && r_b_v) begin
            r_c_present <= r_b_present;
            r_c_x       <= r_b_x;
            r_c_q       <= prod[PW-1:SHIFT_K];
        end
    end

endmodule

// ----- hw/rtl/chdp_window.sv -----
module chdp_window (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  chdp_pkg::t_win_req i_req,
    output logic               o_old,
    output logic               o_busy
);
    import chdp_pkg::*;

    logic             r_mem [0:WINDOW_SECONDS-1];
    logic             r_rd;
    logic             r_clr_busy;
    logic [SLOTW-1:0] r_clr_addr;

    assign o_old  = r_rd;
    assign o_busy = r_clr_busy;

    // Clear one slot per cycle after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == SLOTW'(WINDOW_SECONDS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Forward a write to the same slot in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            if (i_req.wr_en && (i_req.wr_addr == i_req.rd_addr)) begin
                r_rd <= i_req.wr_data;
            end else begin
                r_rd <= r_mem[i_req.rd_addr];
            end
        end
    end

endmodule

// ----- hw/rtl/chdp_status.sv -----
module chdp_status (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_commit,
    input  logic              i_present,
    input  logic              i_old,
    output chdp_pkg::t_status o_stat
);
    import chdp_pkg::*;

    localparam int CMPW = (CNTW > 9) ? CNTW : 9;

    logic [15:0]      r_zeros_to_inactive;
    logic [15:0]      r_seconds_to_active;
    logic [15:0]      r_zeros_to_forget;
    logic [8:0]       r_min_seconds;

    logic [RUN_W-1:0] r_zero_run, n_zero_run;
    logic [RUN_W-1:0] r_processed, n_processed;
    logic             r_active, n_active;
    logic             r_was_active, n_was_active;
    logic [CNTW-1:0]  r_count, n_count;
    logic [CMPW-1:0]  cnt_ext;
    logic             pre_active, pre_was;

    function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
        return (v < RUN_MAX) ? v + 1'b1 : v;
    endfunction

    always_comb begin
        n_zero_run = i_present ? '0 : sat_inc(r_zero_run);

        n_count = r_count;
        if (i_old && !i_present) begin
            n_count = r_count - 1'b1;
        end else if (!i_old && i_present) begin
            n_count = r_count + 1'b1;
        end

        pre_active  = r_active;
        pre_was     = r_was_active;
        n_processed = r_processed;
        if (n_zero_run > RUN_W'(r_zeros_to_inactive)) begin
            pre_active = 1'b0;
        end else if (r_processed > RUN_W'(r_seconds_to_active)) begin
            pre_active  = 1'b1;
            pre_was     = 1'b1;
            n_processed = sat_inc(r_processed);
        end else if (!r_active && r_was_active && (n_zero_run == '0)) begin
            pre_active  = 1'b1;
            n_processed = sat_inc(r_processed);
        end else if (n_zero_run > RUN_W'(r_zeros_to_forget)) begin
            pre_was     = 1'b0;
            n_processed = '0;
        end else if (n_zero_run == '0) begin
            pre_active  = 1'b0;
            n_processed = sat_inc(r_processed);
        end

        cnt_ext = CMPW'(n_count);
        if (cnt_ext < CMPW'(r_min_seconds)) begin
            n_active     = 1'b0;
            n_was_active = 1'b0;
        end else begin
            n_active     = pre_active;
            n_was_active = pre_was;
        end

        o_stat.channel_active    = n_active;
        o_stat.was_active        = n_was_active;
        o_stat.seconds_in_window = (cnt_ext > CMPW'(511)) ? 9'h1FF : cnt_ext[8:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zeros_to_inactive <= 16'd10;
            r_seconds_to_active <= 16'd100;
            r_zeros_to_forget   <= 16'd300;
            r_min_seconds       <= 9'd200;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ZEROS_TO_INACTIVE:     r_zeros_to_inactive <= i_cfg_data;
                CFG_SECONDS_TO_ACTIVE:     r_seconds_to_active <= i_cfg_data;
                CFG_ZEROS_TO_FORGET:       r_zeros_to_forget   <= i_cfg_data;
                CFG_MIN_SECONDS_IN_WINDOW: r_min_seconds       <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run   <= '0;
            r_processed  <= '0;
            r_active     <= 1'b0;
            r_was_active <= 1'b0;
            r_count      <= '0;
        end else if (i_commit) begin
            r_zero_run   <= n_zero_run;
            r_processed  <= n_processed;
            r_active     <= n_active;
            r_was_active <= n_was_active;
            r_count      <= n_count;
        end
    end

endmodule

// ----- hw/rtl/channel_data_presence_tracker.sv -----
// Channel      | Direction | Handshake             | Beat
// -------------+-----------+-----------------------+-------------------------------
// input        | in        | i_in_valid/o_in_stall | rate_count, gps_second
// result       | out       | o_out_valid/i_out_stall | present, active, was_active, count
// config       | in        | i_cfg_we              | i_cfg_idx, i_cfg_data
//
// One beat per clock, sustained while no stall is raised. From acceptance to o_out_valid
// a beat passes slot fold, reciprocal multiply, window read, status update.
// After reset the window is cleared one slot per cycle, all WINDOW_SECONDS slots,
// with o_in_stall high; config writes are taken throughout.
// Stalls only back up into empty stages, so bubbles are filled while a result
// waits on i_out_stall.
module channel_data_presence_tracker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  chdp_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output chdp_pkg::t_out_beat o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data
);
    import chdp_pkg::*;

    logic             slot_ready, slot_valid, slot_present;
    logic [SLOTW-1:0] slot_idx;
    logic             win_busy, win_old;
    t_win_req         win_req;
    t_status          stat;

    // Update stage: holds the slot while its old window bit is read.
    logic             r_d_v;
    logic             r_d_present;
    logic [SLOTW-1:0] r_d_slot;

    logic             r_out_v;
    t_out_beat        r_out;

    logic out_ready, d_ready, commit, accept;

    assign out_ready  = !r_out_v || !i_out_stall;
    assign d_ready    = !r_d_v || out_ready;
    assign commit     = r_d_v && out_ready;
    assign o_in_stall = !slot_ready || win_busy;
    assign accept     = i_in_valid && !o_in_stall;

    chdp_slot u_slot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_data    (i_in_data),
        .i_take    (d_ready),
        .o_ready   (slot_ready),
        .o_valid   (slot_valid),
        .o_present (slot_present),
        .o_slot    (slot_idx)
    );

    // Read the slot as the beat enters the update stage; write it back on commit.
    always_comb begin
        win_req.rd_en   = slot_valid && d_ready;
        win_req.rd_addr = slot_idx;
        win_req.wr_en   = commit;
        win_req.wr_addr = r_d_slot;
        win_req.wr_data = r_d_present;
    end

    chdp_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (win_req),
        .o_old   (win_old),
        .o_busy  (win_busy)
    );

    chdp_status u_status (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_commit   (commit),
        .i_present  (r_d_present),
        .i_old      (win_old),
        .o_stat     (stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (d_ready) r_d_v <= slot_valid;
            if (out_ready) r_out_v <= r_d_v;
        end
    end

    // Advance payloads; hold them while the next stage is stalled.
    always_ff @(posedge i_clk) begin
        if (d_ready && slot_valid) begin
            r_d_present <= slot_present;
            r_d_slot    <= slot_idx;
        end
        if (commit) begin
            r_out.data_present      <= r_d_present;
            r_out.channel_active    <= stat.channel_active;
            r_out.was_active        <= stat.was_active;
            r_out.seconds_in_window <= stat.seconds_in_window;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

// ----- dv/tb_channel_data_presence_tracker.sv -----
`timescale 1ns / 100ps

module tb_channel_data_presence_tracker;
    import chdp_pkg::*;

    // Give up well past the slowest legal run: ~1.6k beats, random gaps and
    // stalls on both sides, the window clear after reset and one long hold.
    localparam int unsigned CYCLE_LIMIT = 100_000;
    // Beats accepted before the receiver starts its long hold.
    localparam int unsigned HOLD_AFTER  = 400;
    localparam int unsigned HOLD_LEN    = 250;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_beat    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_beat   o_out_data;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_idx   = '0;
    logic [15:0] i_cfg_data  = '0;

    channel_data_presence_tracker uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tracker shadow: thresholds and state, kept in step with the block.
    // ------------------------------------------------------------------
    logic [15:0] thr_inactive    = 16'd10;
    logic [15:0] thr_active      = 16'd100;
    logic [15:0] thr_forget      = 16'd300;
    logic [8:0]  thr_min_present = 9'd200;

    logic [RUN_W-1:0] empty_run = '0;   // consecutive seconds without data
    logic [RUN_W-1:0] busy_secs = '0;   // seconds counted toward activation
    logic             act_q     = 1'b0;
    logic             was_q     = 1'b0;
    bit               presence_map [WINDOW_SECONDS];
    int unsigned      set_slots = 0;

    // Status beats still owed by the block, oldest first.
    t_out_beat pending_status [$];

    // Stimulus bookkeeping; beats_in and steady are shared with the receiver.
    int unsigned beats_in   = 0;
    bit          steady     = 1'b0;     // suppress random idling on both sides
    logic [31:0] cursor_sec = 32'd1000;
    int unsigned quiet_left = 0;        // zero-rate seconds left in this gap

    int unsigned mismatches = 0;
    int unsigned cycles     = 0;

    function automatic logic [RUN_W-1:0] sat_step(input logic [RUN_W-1:0] v);
        return (v < RUN_MAX) ? v + 1'b1 : RUN_MAX;
    endfunction

    // Advance the shadow by one second and return the status it should report.
    function automatic t_out_beat track_second(input t_in_beat b);
        t_out_beat   r;
        logic        present;
        int unsigned slot;
        present = (b.rate_count != 16'd0);
        slot    = b.gps_second % $unsigned(WINDOW_SECONDS);

        empty_run = present ? '0 : sat_step(empty_run);

        // Keep the set-slot count in place of a window rescan.
        if (presence_map[slot] && !present)
            set_slots--;
        else if (!presence_map[slot] && present)
            set_slots++;
        presence_map[slot] = present;

        // First matching rule wins.
        if (empty_run > thr_inactive) begin
            act_q = 1'b0;
        end else if (busy_secs > thr_active) begin
            act_q     = 1'b1;
            was_q     = 1'b1;
            busy_secs = sat_step(busy_secs);
        end else if (!act_q && was_q && empty_run == '0) begin
            act_q     = 1'b1;
            busy_secs = sat_step(busy_secs);
        end else if (empty_run > thr_forget) begin
            was_q     = 1'b0;
            busy_secs = '0;
        end else if (empty_run == '0) begin
            act_q     = 1'b0;
            busy_secs = sat_step(busy_secs);
        end

        // Too little data in the window overrides everything.
        if (set_slots < thr_min_present) begin
            act_q = 1'b0;
            was_q = 1'b0;
        end

        r.data_present      = present;
        r.channel_active    = act_q;
        r.was_active        = was_q;
        r.seconds_in_window = (set_slots > 511) ? 9'd511 : 9'(set_slots);
        return r;
    endfunction

    // Mostly a well-formed stream of consecutive seconds with data and
    // occasional empty gaps; the rest repeats, skips or jumps anywhere.
    function automatic t_in_beat draw_second();
        t_in_beat    b;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            b.gps_second = cursor_sec;
            cursor_sec   = cursor_sec + 32'd1;
            if (quiet_left == 0 && $urandom_range(0, 99) < 4)
                quiet_left = $urandom_range(1, 40);
            if (quiet_left != 0) begin
                b.rate_count = 16'd0;
                quiet_left--;
            end else begin
                b.rate_count = 16'($urandom_range(1, 65535));
            end
        end else if (pick < 90) begin
            // Same second again: overwrite the slot.
            b.gps_second = cursor_sec - 32'd1;
            b.rate_count = 16'($urandom);
        end else if (pick < 95) begin
            // Skip ahead: the slots in between keep their old value.
            cursor_sec   = cursor_sec + 32'($urandom_range(1, 600));
            b.gps_second = cursor_sec;
            cursor_sec   = cursor_sec + 32'd1;
            b.rate_count = 16'($urandom);
        end else begin
            b.gps_second = $urandom();
            b.rate_count = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'($urandom);
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------

    // Offer one beat, idling at random first; hold it until accepted and
    // queue the status it must produce (the typed one where it is given).
    task automatic offer(input t_in_beat b, input bit known, input t_out_beat want);
        t_out_beat p;
        while (!steady && $urandom_range(0, 99) < 26) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall);
        p = track_second(b);
        pending_status.push_back(known ? want : p);
        beats_in++;
    endtask

    // Drop valid and wait until every queued status has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_status.size() != 0);
    endtask

    // Write all four thresholds back to back; only called while idle.
    task automatic load_thresholds(input logic [15:0] z_in, s_act, z_fg, min_w);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ZEROS_TO_INACTIVE;
        i_cfg_data <= z_in;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SECONDS_TO_ACTIVE;
        i_cfg_data <= s_act;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ZEROS_TO_FORGET;
        i_cfg_data <= z_fg;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MIN_SECONDS_IN_WINDOW;
        i_cfg_data <= min_w;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        thr_inactive    = z_in;
        thr_active      = s_act;
        thr_forget      = z_fg;
        thr_min_present = min_w[8:0];   // register keeps nine bits
    endtask

    // One threshold setting and a burst of random seconds under it.
    // pause_at picks a beat before which the sender waits for a full drain.
    task automatic run_phase(input logic [15:0] z_in, s_act, z_fg, min_w,
                             input int n, input int pause_at);
        load_thresholds(z_in, s_act, z_fg, min_w);
        for (int k = 0; k < n; k++) begin
            if (k == pause_at)
                drain_results();
            offer(draw_second(), 1'b0, '0);
        end
        drain_results();
    endtask

    // Directed seconds under the reset thresholds. The window never reaches
    // 200 set slots here, so both flags read zero and the count is plain.
    typedef struct {
        logic [15:0] rate;
        logic [31:0] sec;
        bit          known;
        t_out_beat   want;
    } t_probe_row;

    localparam int N_PROBES = 24;
    t_probe_row probes [N_PROBES] = '{
        // empty second straight after reset
        '{16'h0000, 32'd0,          1'b1, '{1'b0, 1'b0, 1'b0, 9'd0}},
        // full-scale rate sets slot 0
        '{16'hFFFF, 32'd0,          1'b1, '{1'b1, 1'b0, 1'b0, 9'd1}},
        // last slot of the window
        '{16'h0001, 32'd299,        1'b1, '{1'b1, 1'b0, 1'b0, 9'd2}},
        // 300 folds onto slot 0, already set
        '{16'h0001, 32'd300,        1'b1, '{1'b1, 1'b0, 1'b0, 9'd2}},
        // same second without data clears slot 0
        '{16'h0000, 32'd300,        1'b1, '{1'b0, 1'b0, 1'b0, 9'd1}},
        // top second lands on slot 195
        '{16'h8000, 32'hFFFF_FFFF,  1'b1, '{1'b1, 1'b0, 1'b0, 9'd2}},
        '{16'h0000, 32'hFFFF_FFFF,  1'b1, '{1'b0, 1'b0, 1'b0, 9'd1}},
        // empty second on a slot never visited
        '{16'h0000, 32'd1,          1'b1, '{1'b0, 1'b0, 1'b0, 9'd1}},
        '{16'h7FFF, 32'h8000_0000,  1'b1, '{1'b1, 1'b0, 1'b0, 9'd2}},
        '{16'hAAAA, 32'h5555_5555,  1'b1, '{1'b1, 1'b0, 1'b0, 9'd3}},
        '{16'h5555, 32'hAAAA_AAAA,  1'b1, '{1'b1, 1'b0, 1'b0, 9'd4}},
        // empty run past zeros_to_inactive, then data again
        '{16'h0000, 32'd2,          1'b0, '0},
        '{16'h0000, 32'd3,          1'b0, '0},
        '{16'h0000, 32'd4,          1'b0, '0},
        '{16'h0000, 32'd5,          1'b0, '0},
        '{16'h0000, 32'd6,          1'b0, '0},
        '{16'h0000, 32'd7,          1'b0, '0},
        '{16'h0000, 32'd8,          1'b0, '0},
        '{16'h0000, 32'd9,          1'b0, '0},
        '{16'h0000, 32'd10,         1'b0, '0},
        '{16'h0000, 32'd11,         1'b0, '0},
        '{16'h0000, 32'd12,         1'b0, '0},
        '{16'h0000, 32'd13,         1'b0, '0},
        '{16'h0001, 32'd14,         1'b0, '0}
    };

    initial begin
        t_in_beat b;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table; the block stalls through its window clear.
        foreach (probes[i]) begin
            b.rate_count = probes[i].rate;
            b.gps_second = probes[i].sec;
            offer(b, probes[i].known, probes[i].want);
        end
        drain_results();

        // Low extremes: any empty second deactivates at once; the inactive rule wins before forgetting.
        run_phase(16'd0, 16'd0, 16'd0, 16'd0, 200, -1);
        // Quick activation; the receiver's long hold lands in here.
        run_phase(16'd4, 16'd12, 16'd400, 16'd60, 200, -1);
        // Activation threshold out of reach: only re-activation of a
        // was-active channel can raise the flag.
        run_phase(16'd6, 16'hFFFF, 16'hFFFF, 16'd60, 200, -1);
        // Forget threshold below the inactive one; sender pauses mid-phase.
        run_phase(16'd30, 16'd8, 16'd3, 16'd20, 200, 100);
        // High extremes; the minimum register keeps nine bits, so 511 here.
        cursor_sec = 32'hFFFF_FF80;     // stream wraps the 32-bit second
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 200, -1);
        // Reset values again, without any idling.
        steady = 1'b1;
        run_phase(16'd10, 16'd100, 16'd300, 16'd200, 200, -1);
        steady = 1'b0;
        run_phase(16'($urandom_range(0, 40)), 16'($urandom_range(0, 200)),
                  16'($urandom_range(0, 80)), 16'($urandom_range(0, 300)), 200, -1);
        // Full window required.
        run_phase(16'd2, 16'd1, 16'd5, 16'd300, 200, -1);

        drain_results();
        // Leave room for anything stray to show up.
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && pending_status.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver side: check each accepted beat, then pick the next stall.
    // ------------------------------------------------------------------
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    always @(posedge i_clk) begin
        t_out_beat exp_beat;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected status beat: %p", o_out_data);
            end else begin
                exp_beat = pending_status.pop_front();
                if (o_out_data.data_present      !== exp_beat.data_present   ||
                    o_out_data.channel_active    !== exp_beat.channel_active ||
                    o_out_data.was_active        !== exp_beat.was_active     ||
                    o_out_data.seconds_in_window !== exp_beat.seconds_in_window) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("status mismatch: expected %p, got %p",
                                 exp_beat, o_out_data);
                end
            end
        end

        // Hold off once for a long stretch so the pipe backs up into the
        // input; otherwise stall at random.
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && beats_in >= HOLD_AFTER) begin
            hold_left   <= HOLD_LEN;
            hold_done   <= 1'b1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !steady && ($urandom_range(0, 99) < 26);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
